[hdl/tpi_pkg.sv]
// Shared types and constants for the three-plane intersection unit.
// No dependencies; used by tpi_cramer, tpi_div_lane and the top level.
package tpi_pkg;

	localparam int FIELD_W    = 32;
	localparam int PROD_W     = 64;
	localparam int CROSS_W    = 65;
	localparam int TERM_W     = 97;
	localparam int SUM_W      = 99;
	localparam int QUOT_W     = 34;
	localparam int NUM_AXES   = 3;
	localparam int CRAMER_LAT = 5;
	localparam int LANE_PRE   = 2;
	localparam int LANE_LAT   = LANE_PRE + QUOT_W + 1;
	localparam int TOTAL_LAT  = CRAMER_LAT + LANE_LAT;

	typedef logic signed [FIELD_W-1:0] fix_t;
	typedef logic signed [SUM_W-1:0]   sum_t;
	typedef logic [SUM_W-1:0]          mag_t;

	localparam fix_t FIX_MAX = {1'b0, {(FIELD_W-1){1'b1}}};
	localparam fix_t FIX_MIN = {1'b1, {(FIELD_W-1){1'b0}}};

endpackage

[hdl/three_plane_intersection_unit.sv]
// Three-plane intersection unit: top level with stream handshake and valid pipeline.
// Instantiates tpi_cramer and three tpi_div_lane; depends on tpi_pkg.
//
// Usage:
//   Input channel s_*: one transaction carries three planes, each a normal
//   (x, y, z) and an offset, all signed fixed point with FRAC_BITS fraction
//   bits. Output channel m_*: one transaction per input with the point
//   (x, y, z) in m_tdata and the singular flag in m_tuser.
//   From input transaction to m_tvalid the path runs through five stages of
//   cross products, split multiplies and sums, two stages of magnitude and
//   range check, 34 restoring-division stages (one quotient bit each) and
//   the output register.
//   Throughput is one transaction per cycle while m_tready stays high.
//   A stall on m_tready with a full output register freezes the whole
//   pipeline and drops s_tready; nothing is lost or repeated.
//   Reset clears all valid bits; the pipeline comes out empty.
//   A zero determinant gives the zero point with the singular flag set.
module three_plane_intersection_unit #(
	parameter int FRAC_BITS = 16
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	// 12 x 32: first_normal_x/y/z, first_offset, second_..., third_... (low first)
	input  logic [383:0] s_tdata,
	output logic         m_tvalid,
	input  logic         m_tready,
	// point_x [31:0], point_y [63:32], point_z [95:64]
	output logic [95:0]  m_tdata,
	// singular [0]
	output logic [0:0]   m_tuser
);

	localparam int LAT = tpi_pkg::TOTAL_LAT;

	logic              adv;
	logic [LAT-1:0]    vld_q;
	tpi_pkg::fix_t     nrm [3][3];
	tpi_pkg::fix_t     ofs [3];
	tpi_pkg::sum_t     det;
	tpi_pkg::sum_t     num [3];
	tpi_pkg::fix_t     point [3];
	logic [2:0]        sing;

	assign adv      = !vld_q[LAT-1] || m_tready;
	assign s_tready = adv;
	assign m_tvalid = vld_q[LAT-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (adv) begin
			vld_q <= {vld_q[LAT-2:0], s_tvalid};
		end
	end

	for (genvar i = 0; i < 3; i++) begin : g_plane
		for (genvar k = 0; k < 3; k++) begin : g_axis
			assign nrm[i][k] = tpi_pkg::fix_t'(s_tdata[(4*i+k)*32 +: 32]);
		end
		assign ofs[i] = tpi_pkg::fix_t'(s_tdata[(4*i+3)*32 +: 32]);
	end

	tpi_cramer u_cramer (
		.clk (clk),
		.en  (adv),
		.nrm (nrm),
		.ofs (ofs),
		.det (det),
		.num (num)
	);

	for (genvar k = 0; k < tpi_pkg::NUM_AXES; k++) begin : g_lane
		tpi_div_lane #(
			.FRAC_BITS (FRAC_BITS)
		) u_lane (
			.clk   (clk),
			.en    (adv),
			.num   (num[k]),
			.det   (det),
			.point (point[k]),
			.zero  (sing[k])
		);
		assign m_tdata[k*32 +: 32] = point[k];
	end

	assign m_tuser[0] = &sing;

endmodule

[hdl/tpi_cramer.sv]
// Cramer front end: cross products, determinant and coordinate numerators.
// Five register stages; depends on tpi_pkg.
module tpi_cramer (
	input  logic        clk,
	input  logic        en,
	input  tpi_pkg::fix_t nrm [3][3],
	input  tpi_pkg::fix_t ofs [3],
	output tpi_pkg::sum_t det,
	output tpi_pkg::sum_t num [3]
);

	logic signed [tpi_pkg::PROD_W-1:0]  pa_s1 [3][3];
	logic signed [tpi_pkg::PROD_W-1:0]  pb_s1 [3][3];
	tpi_pkg::fix_t                      n0_s1 [3];
	tpi_pkg::fix_t                      d_s1  [3];
	logic signed [tpi_pkg::CROSS_W-1:0] c_s2  [3][3];
	tpi_pkg::fix_t                      n0_s2 [3];
	tpi_pkg::fix_t                      d_s2  [3];
	logic signed [tpi_pkg::CROSS_W-1:0] dl_s3 [3];
	logic signed [tpi_pkg::CROSS_W-1:0] dh_s3 [3];
	logic signed [tpi_pkg::CROSS_W-1:0] nl_s3 [3][3];
	logic signed [tpi_pkg::CROSS_W-1:0] nh_s3 [3][3];
	logic signed [tpi_pkg::TERM_W-1:0]  dt_s4 [3];
	logic signed [tpi_pkg::TERM_W-1:0]  nt_s4 [3][3];
	tpi_pkg::sum_t                      det_s5;
	tpi_pkg::sum_t                      num_s5 [3];

	for (genvar i = 0; i < 3; i++) begin : g_row
		always_ff @(posedge clk) begin
			if (en) begin
				n0_s1[i] <= nrm[0][i];
				d_s1[i]  <= ofs[i];
				n0_s2[i] <= n0_s1[i];
				d_s2[i]  <= d_s1[i];
				dl_s3[i] <= n0_s2[i] * $signed({1'b0, c_s2[0][i][31:0]});
				dh_s3[i] <= n0_s2[i] * $signed(c_s2[0][i][64:32]);
				dt_s4[i] <= (tpi_pkg::TERM_W'(dh_s3[i]) <<< 32) + tpi_pkg::TERM_W'(dl_s3[i]);
			end
		end
		for (genvar k = 0; k < 3; k++) begin : g_col
			always_ff @(posedge clk) begin
				if (en) begin
					pa_s1[i][k] <= nrm[(i+1)%3][(k+1)%3] * nrm[(i+2)%3][(k+2)%3];
					pb_s1[i][k] <= nrm[(i+1)%3][(k+2)%3] * nrm[(i+2)%3][(k+1)%3];
					c_s2[i][k]  <= tpi_pkg::CROSS_W'(pa_s1[i][k])
						- tpi_pkg::CROSS_W'(pb_s1[i][k]);
					nl_s3[i][k] <= d_s2[i] * $signed({1'b0, c_s2[i][k][31:0]});
					nh_s3[i][k] <= d_s2[i] * $signed(c_s2[i][k][64:32]);
					nt_s4[i][k] <= (tpi_pkg::TERM_W'(nh_s3[i][k]) <<< 32)
						+ tpi_pkg::TERM_W'(nl_s3[i][k]);
				end
			end
		end
		always_ff @(posedge clk) begin
			if (en) begin
				num_s5[i] <= tpi_pkg::SUM_W'(nt_s4[0][i]) + tpi_pkg::SUM_W'(nt_s4[1][i])
					+ tpi_pkg::SUM_W'(nt_s4[2][i]);
			end
		end
		assign num[i] = num_s5[i];
	end

	always_ff @(posedge clk) begin
		if (en) begin
			det_s5 <= tpi_pkg::SUM_W'(dt_s4[0]) + tpi_pkg::SUM_W'(dt_s4[1])
				+ tpi_pkg::SUM_W'(dt_s4[2]);
		end
	end

	assign det = det_s5;

endmodule

[hdl/tpi_div_lane.sv]
// One coordinate lane: pipelined restoring division with rounding and saturation.
// One quotient bit per stage; depends on tpi_pkg.
module tpi_div_lane #(
	parameter int FRAC_BITS = 16
) (
	input  logic          clk,
	input  logic          en,
	input  tpi_pkg::sum_t num,
	input  tpi_pkg::sum_t det,
	output tpi_pkg::fix_t point,
	output logic          zero
);

	localparam int X_W = tpi_pkg::SUM_W + FRAC_BITS + 1;
	localparam int R_W = tpi_pkg::SUM_W + 1;
	localparam int QW  = tpi_pkg::QUOT_W;

	tpi_pkg::mag_t   nmag_s1, dmag_s1;
	logic            neg_s1, zero_s1;
	logic [X_W-1:0]  x_s1;

	tpi_pkg::mag_t   rem_s [QW+1];
	tpi_pkg::mag_t   dm_s  [QW+1];
	logic [QW-1:0]   low_s [QW+1];
	logic [QW-1:0]   quo_s [QW+1];
	logic            neg_s [QW+1];
	logic            sat_s [QW+1];
	logic            zro_s [QW+1];

	tpi_pkg::fix_t   point_s;
	logic            zero_s;
	logic [QW:0]     inc;
	logic [QW-1:0]   qr;

	assign x_s1 = {nmag_s1, {(FRAC_BITS+1){1'b0}}};

	always_ff @(posedge clk) begin
		if (en) begin
			nmag_s1 <= num[tpi_pkg::SUM_W-1] ? tpi_pkg::mag_t'(-num) : tpi_pkg::mag_t'(num);
			dmag_s1 <= det[tpi_pkg::SUM_W-1] ? tpi_pkg::mag_t'(-det) : tpi_pkg::mag_t'(det);
			neg_s1  <= num[tpi_pkg::SUM_W-1] ^ det[tpi_pkg::SUM_W-1];
			zero_s1 <= (det == '0);
			rem_s[0] <= tpi_pkg::mag_t'(x_s1[X_W-1:QW]);
			sat_s[0] <= tpi_pkg::mag_t'(x_s1[X_W-1:QW]) >= dmag_s1;
			low_s[0] <= x_s1[QW-1:0];
			quo_s[0] <= '0;
			dm_s[0]  <= dmag_s1;
			neg_s[0] <= neg_s1;
			zro_s[0] <= zero_s1;
		end
	end

	for (genvar j = 1; j <= QW; j++) begin : g_step
		logic [R_W-1:0] t;
		logic           ge;
		assign t  = {rem_s[j-1], low_s[j-1][QW-1]};
		assign ge = t >= {1'b0, dm_s[j-1]};
		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[j] <= ge ? tpi_pkg::mag_t'(t - {1'b0, dm_s[j-1]}) : tpi_pkg::mag_t'(t);
				low_s[j] <= {low_s[j-1][QW-2:0], 1'b0};
				quo_s[j] <= {quo_s[j-1][QW-2:0], ge};
				dm_s[j]  <= dm_s[j-1];
				neg_s[j] <= neg_s[j-1];
				sat_s[j] <= sat_s[j-1];
				zro_s[j] <= zro_s[j-1];
			end
		end
	end

	assign inc = {1'b0, quo_s[QW]} + 1'b1;
	assign qr  = inc[QW:1];

	always_ff @(posedge clk) begin
		if (en) begin
			zero_s <= zro_s[QW];
			if (zro_s[QW]) begin
				point_s <= '0;
			end else if (sat_s[QW]) begin
				point_s <= neg_s[QW] ? tpi_pkg::FIX_MIN : tpi_pkg::FIX_MAX;
			end else if (!neg_s[QW]) begin
				point_s <= (qr > QW'(tpi_pkg::FIX_MAX)) ? tpi_pkg::FIX_MAX
					: tpi_pkg::fix_t'(qr[tpi_pkg::FIELD_W-1:0]);
			end else begin
				point_s <= (qr > QW'({1'b0, tpi_pkg::FIX_MIN})) ? tpi_pkg::FIX_MIN
					: tpi_pkg::fix_t'(-qr[tpi_pkg::FIELD_W-1:0]);
			end
		end
	end

	assign point = point_s;
	assign zero  = zero_s;

endmodule

[verif/tpi_checker.sv]
// Checker for the three-plane intersection unit: watches both stream channels,
// predicts each point by an exact Cramer solve and compares. Depends on tpi_pkg.
module tpi_checker #(
	parameter int FRAC_BITS = 16
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	input  logic         s_tready,
	input  logic [383:0] s_tdata,
	input  logic         m_tvalid,
	input  logic         m_tready,
	input  logic [95:0]  m_tdata,
	input  logic [0:0]   m_tuser,
	output int           fail_count,
	output int           pending,
	output int           points_seen,
	output int           singular_seen
);
	timeunit 1ns;
	timeprecision 1ps;

	typedef logic signed [127:0] wide_t;

	typedef struct {
		tpi_pkg::fix_t x;
		tpi_pkg::fix_t y;
		tpi_pkg::fix_t z;
		logic sing;
	} point_t;

	point_t expected_points[$];

	function automatic tpi_pkg::fix_t round_sat(input wide_t num, input wide_t det);
		logic [127:0] an, ad, q, r;
		logic neg;
		an  = num[127] ? -num : num;
		ad  = det[127] ? -det : det;
		q   = an / ad;
		r   = an % ad;
		if ((r << 1) >= ad)
			q = q + 1;
		neg = num[127] ^ det[127];
		if (!neg) begin
			if (q > 128'h7FFF_FFFF)
				return tpi_pkg::FIX_MAX;
			return tpi_pkg::fix_t'(q[31:0]);
		end
		if (q > 128'h8000_0000)
			return tpi_pkg::FIX_MIN;
		return tpi_pkg::fix_t'(-q[31:0]);
	endfunction

	function automatic point_t solve_planes(input logic [383:0] planes);
		wide_t n[3][3];
		wide_t d[3];
		wide_t c[3][3];
		wide_t det;
		wide_t num;
		tpi_pkg::fix_t coord[3];
		point_t p;
		for (int i = 0; i < 3; i++) begin
			for (int k = 0; k < 3; k++)
				n[i][k] = wide_t'($signed(planes[(i*4+k)*32 +: 32]));
			d[i] = wide_t'($signed(planes[(i*4+3)*32 +: 32]));
		end
		for (int i = 0; i < 3; i++) begin
			int a, b;
			a = (i + 1) % 3;
			b = (i + 2) % 3;
			c[i][0] = n[a][1] * n[b][2] - n[a][2] * n[b][1];
			c[i][1] = n[a][2] * n[b][0] - n[a][0] * n[b][2];
			c[i][2] = n[a][0] * n[b][1] - n[a][1] * n[b][0];
		end
		det = n[0][0] * c[0][0] + n[0][1] * c[0][1] + n[0][2] * c[0][2];
		if (det == 0) begin
			p.x = '0;
			p.y = '0;
			p.z = '0;
			p.sing = 1'b1;
			return p;
		end
		for (int k = 0; k < 3; k++) begin
			num = d[0] * c[0][k] + d[1] * c[1][k] + d[2] * c[2][k];
			coord[k] = round_sat(num <<< FRAC_BITS, det);
		end
		p.x = coord[0];
		p.y = coord[1];
		p.z = coord[2];
		p.sing = 1'b0;
		return p;
	endfunction

	task automatic report_mismatch(input string what, input logic [31:0] got,
			input logic [31:0] want);
		$display("[%0t] MISMATCH %s: got %h expected %h", $realtime, what, got, want);
		fail_count++;
	endtask

	initial begin
		fail_count = 0;
		points_seen = 0;
		singular_seen = 0;
	end

	assign pending = expected_points.size();

	always @(posedge clk) begin
		point_t want;
		if (arst_n) begin
			if (s_tvalid && s_tready)
				expected_points.push_back(solve_planes(s_tdata));
			if (m_tvalid && m_tready) begin
				points_seen++;
				if (m_tuser[0])
					singular_seen++;
				if (expected_points.size() == 0) begin
					report_mismatch("unexpected transaction", m_tdata[31:0], '0);
				end else begin
					want = expected_points.pop_front();
					if (m_tdata[31:0] !== want.x)
						report_mismatch("point_x", m_tdata[31:0], want.x);
					if (m_tdata[63:32] !== want.y)
						report_mismatch("point_y", m_tdata[63:32], want.y);
					if (m_tdata[95:64] !== want.z)
						report_mismatch("point_z", m_tdata[95:64], want.z);
					if (m_tuser[0] !== want.sing)
						report_mismatch("singular", 32'(m_tuser[0]), 32'(want.sing));
				end
			end
		end
	end

endmodule

[verif/tb_three_plane_intersection_unit.sv]
// Testbench top for the three-plane intersection unit: clock, reset, plane stimulus
// with bursty valid and stalling ready, verdict. Depends on tpi_pkg and tpi_checker.
module tb_three_plane_intersection_unit;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int FRAC = 16;
	localparam int RANDOM_ITEMS = 600;
	localparam int IDLE_LIMIT = 5000;

	logic         clk = 1'b0;
	logic         arst_n = 1'b0;
	logic         s_tvalid = 1'b0;
	logic         s_tready;
	logic [383:0] s_tdata = '0;
	logic         m_tvalid;
	logic         m_tready = 1'b0;
	logic [95:0]  m_tdata;
	logic [0:0]   m_tuser;
	logic         in_taken = 1'b0;
	int           fail_count, pending, points_seen, singular_seen;
	int           idle_cycles = 0;
	int           sent = 0;

	always #6 clk = ~clk;

	three_plane_intersection_unit #(.FRAC_BITS(FRAC)) u_top (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
	);

	tpi_checker #(.FRAC_BITS(FRAC)) u_checker (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
		.fail_count(fail_count), .pending(pending),
		.points_seen(points_seen), .singular_seen(singular_seen)
	);

	always @(posedge clk) begin
		in_taken <= s_tvalid && s_tready;
		if (arst_n && !(s_tvalid && s_tready) && !(m_tvalid && m_tready))
			idle_cycles <= idle_cycles + 1;
		else
			idle_cycles <= 0;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("Watchdog expired after %0d idle cycles", idle_cycles);
			$display("Simulation FAILED");
			$finish;
		end
	end

	// stall pattern: alternate calm, choppy and mostly-blocked stretches
	always @(negedge clk) begin
		int mode, left;
		if (left <= 0) begin
			mode = $urandom_range(0, 3);
			left = $urandom_range(5, 60);
		end
		left--;
		case (mode)
			0: m_tready <= 1'b1;
			1: m_tready <= 1'($urandom_range(0, 1));
			2: m_tready <= ($urandom_range(0, 4) == 0);
			default: m_tready <= ($urandom_range(0, 3) != 0);
		endcase
	end

	function automatic tpi_pkg::fix_t small_fix();
		return tpi_pkg::fix_t'($signed($urandom_range(0, 16'hFFFF) << $urandom_range(0, 8))
			>>> 8);
	endfunction

	function automatic logic [383:0] pack_planes(input tpi_pkg::fix_t f[12]);
		logic [383:0] v;
		for (int i = 0; i < 12; i++)
			v[i*32 +: 32] = f[i];
		return v;
	endfunction

	task automatic send_planes(input logic [383:0] planes);
		s_tdata  = planes;
		s_tvalid = 1'b1;
		do @(negedge clk); while (!in_taken);
		sent++;
	endtask

	task automatic gap_maybe();
		if ($urandom_range(0, 5) == 0) begin
			s_tvalid = 1'b0;
			repeat ($urandom_range(1, 12)) @(negedge clk);
		end
	endtask

	function automatic logic [383:0] random_planes();
		tpi_pkg::fix_t f[12];
		int kind;
		kind = $urandom_range(0, 9);
		for (int i = 0; i < 12; i++) begin
			case (kind) inside
				[0:2]: f[i] = tpi_pkg::fix_t'($urandom);
				[3:5]: f[i] = small_fix();
				6: f[i] = (i % 4 == 3) ? tpi_pkg::fix_t'($urandom) : small_fix();
				7: f[i] = (i % 4 == 3) ? small_fix()
						: tpi_pkg::fix_t'($urandom_range(0, 7) - 3);
				default: f[i] = (i % 5 == 0) ? (32'sd1 <<< FRAC) + small_fix()
						: ((i % 4 == 3) ? tpi_pkg::fix_t'($urandom) : small_fix() >>> 4);
			endcase
		end
		if ($urandom_range(0, 7) == 0) begin
			for (int k = 0; k < 3; k++)
				f[8 + k] = ($urandom_range(0, 1)) ? f[k] : f[4 + k];
		end
		return pack_planes(f);
	endfunction

	initial begin
		tpi_pkg::fix_t f[12];
		tpi_pkg::fix_t one;
		one = 32'sd1 <<< FRAC;
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		repeat (3) @(negedge clk);

		// all zero: singular
		foreach (f[i]) f[i] = '0;
		send_planes(pack_planes(f));
		// identity normals with offsets at the extremes
		foreach (f[i]) f[i] = '0;
		f[0] = one; f[5] = one; f[10] = one;
		f[3] = tpi_pkg::FIX_MAX; f[7] = tpi_pkg::FIX_MIN; f[11] = 32'sd12345;
		send_planes(pack_planes(f));
		// every field at the maximum, then the minimum: singular
		foreach (f[i]) f[i] = tpi_pkg::FIX_MAX;
		send_planes(pack_planes(f));
		foreach (f[i]) f[i] = tpi_pkg::FIX_MIN;
		send_planes(pack_planes(f));
		// tiny normals, huge offsets: saturate both ways
		foreach (f[i]) f[i] = '0;
		f[0] = 32'sd1; f[5] = 32'sd1; f[10] = -32'sd1;
		f[3] = tpi_pkg::FIX_MAX; f[7] = tpi_pkg::FIX_MIN; f[11] = tpi_pkg::FIX_MAX;
		send_planes(pack_planes(f));
		// extreme diagonal with min- and max-valued normals
		foreach (f[i]) f[i] = '0;
		f[0] = tpi_pkg::FIX_MIN; f[5] = tpi_pkg::FIX_MAX; f[10] = tpi_pkg::FIX_MIN;
		f[3] = tpi_pkg::FIX_MIN; f[7] = tpi_pkg::FIX_MAX; f[11] = 32'sd1;
		send_planes(pack_planes(f));
		// parallel planes with distinct offsets: singular
		foreach (f[i]) f[i] = '0;
		f[0] = one; f[4] = one; f[8] = -one;
		f[3] = one; f[7] = 32'sd5; f[11] = -32'sd7;
		send_planes(pack_planes(f));
		// diagonal of two: half-valued coordinates of both signs
		foreach (f[i]) f[i] = '0;
		f[0] = 32'sd2; f[5] = 32'sd2; f[10] = 32'sd2;
		f[3] = 32'sd1; f[7] = -32'sd1; f[11] = 32'sd3;
		send_planes(pack_planes(f));
		// diagonal of three: thirds below and above the tie
		foreach (f[i]) f[i] = '0;
		f[0] = 32'sd3; f[5] = 32'sd3; f[10] = -32'sd3;
		f[3] = 32'sd1; f[7] = 32'sd2; f[11] = -32'sd2;
		send_planes(pack_planes(f));
		// all ones pattern bits
		foreach (f[i]) f[i] = tpi_pkg::fix_t'(32'hFFFF_FFFF);
		f[0] = 32'sh5555_5555; f[5] = 32'shAAAA_AAAA; f[10] = 32'sh0F0F_F0F0;
		send_planes(pack_planes(f));
		s_tvalid = 1'b0;

		for (int i = 0; i < RANDOM_ITEMS; i++) begin
			if (i == RANDOM_ITEMS / 2) begin
				s_tvalid = 1'b0;
				while (pending != 0) @(negedge clk);
			end
			send_planes(random_planes());
			if ($urandom_range(0, 3) == 0)
				gap_maybe();
		end
		s_tvalid = 1'b0;

		while (pending != 0) @(negedge clk);
		repeat (tpi_pkg::TOTAL_LAT + 20) @(negedge clk);

		$display("Sent %0d plane triples, checked %0d points (%0d singular)",
			sent, points_seen, singular_seen);
		$display("Stimulus mixed full-range, small-magnitude, near-identity and degenerate sets");
		if (fail_count == 0 && pending == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule

[sim.f]
hdl/tpi_pkg.sv
hdl/tpi_cramer.sv
hdl/tpi_div_lane.sv
hdl/three_plane_intersection_unit.sv
verif/tpi_checker.sv
verif/tb_three_plane_intersection_unit.sv
